FILE: rtl/hsa_pkg.sv
// Shared types and constants for the pixel hue/saturation adjust block.
// No dependencies; the top module and the bench import this package.
`timescale 1ns / 1ps
`default_nettype none

package hsa_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CHAN_W        = 16;
	localparam int CFG_W         = 24;
	localparam int HOFF_W        = 18;
	localparam int GAIN_W        = 24;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_MODE       = 2'd0;
	localparam logic [1:0] REG_HUE_OFFSET = 2'd1;
	localparam logic [1:0] REG_SAT_GAIN   = 2'd2;

	typedef enum logic [1:0] {
		MODE_TO_HSV    = 2'd0,
		MODE_TO_RGB    = 2'd1,
		MODE_HUE_SHIFT = 2'd2,
		MODE_SAT_SCALE = 2'd3
	} mode_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan_in_a;
		logic [CHAN_W-1:0] chan_in_b;
		logic [CHAN_W-1:0] chan_in_c;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan_out_a;
		logic [CHAN_W-1:0] chan_out_b;
		logic [CHAN_W-1:0] chan_out_c;
	} pix_out_t;

endpackage

`default_nettype wire

FILE: rtl/hsa_div.sv
// Pipelined restoring divider, one quotient bit per stage, for num <= den.
// Gives floor(num * 2^(QB-1) / den). No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module hsa_div #(
	parameter int DW = 19,
	parameter int QB = 17
) (
	input  logic          clk,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QB-1:0] quo
);

	logic [DW-1:0] rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] quo_s [QB];

	always_ff @(posedge clk) begin
		den_s[0] <= den;
		if (num >= den) begin
			rem_s[0] <= num - den;
			quo_s[0] <= {{(QB-1){1'b0}}, 1'b1};
		end else begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k < QB; k++) begin : g_step
		logic [DW:0] two_rem;
		logic [DW:0] diff;
		logic        ge;

		assign two_rem = {rem_s[k-1], 1'b0};
		assign diff    = two_rem - {1'b0, den_s[k-1]};
		assign ge      = two_rem >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			den_s[k] <= den_s[k-1];
			rem_s[k] <= ge ? diff[DW-1:0] : two_rem[DW-1:0];
			quo_s[k] <= {quo_s[k-1][QB-2:0], ge};
		end
	end

	assign quo = quo_s[QB-1];

endmodule

`default_nettype wire

FILE: rtl/pixel_hue_saturation_adjust_top.sv
// Pixel hue/saturation adjust: fixed-point RGB <-> HSV, hue shift and saturation scale.
// Depends on hsa_pkg and hsa_div.
//
// One pixel enters per clock (busy stays low) and its result is shown for exactly one cycle
// with done high; the receiver cannot stall. The result passes through an input stage,
// the two pipelined dividers for saturation and hue, one quotient bit per stage, and
// five stages for the hue shift, saturation gain and HSV to RGB products. Write
// configuration only while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module pixel_hue_saturation_adjust_top #(
	parameter int FRAC_BITS = hsa_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  hsa_pkg::pix_in_t               pix_in,
	output logic                           done,
	output hsa_pkg::pix_out_t              pix_out,
	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_index,
	input  logic [hsa_pkg::CFG_W-1:0]      cfg_wdata
);
	import hsa_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int QB = F + 1;
	localparam int DW = 19;
	localparam int XW = ((F > 16) ? F : 16) + 1;
	localparam int OW = (F > 18) ? F : 18;
	localparam int CW = XW + 4;
	localparam int PW = QB + GAIN_W;

	localparam logic [F:0]           ONE     = {1'b1, {F{1'b0}}};
	localparam logic [CHAN_W-1:0]    LIM     = (F >= 16) ? 16'hFFFF : 16'((64'd1 << F) - 64'd1);
	localparam logic signed [CW-1:0] ONE_C   = CW'(64'd1 << F);
	localparam logic signed [CW-1:0] TWO_C   = CW'(64'd2 << F);
	localparam logic signed [CW-1:0] THREE_C = CW'(64'd3 << F);
	localparam logic signed [CW-1:0] FOUR_C  = CW'(64'd4 << F);

	typedef struct packed {
		mode_t             mode;
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] c;
		logic [CHAN_W-1:0] mx;
		logic              flat;
	} side_t;

	function automatic logic [CHAN_W-1:0] sat16(input logic [31:0] x);
		return (x > 32'(LIM)) ? LIM : x[CHAN_W-1:0];
	endfunction

	function automatic logic signed [CW-1:0] absv(input logic signed [CW-1:0] x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic logic [F:0] clip_c(input logic signed [CW-1:0] x);
		if (x < 0)
			return '0;
		else if (x > ONE_C)
			return ONE;
		else
			return x[F:0];
	endfunction

	// configuration registers
	mode_t               mode_q;
	logic [HOFF_W-1:0]   hoff_q;
	logic [GAIN_W-1:0]   gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TO_HSV;
			hoff_q <= '0;
			gain_q <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE:       mode_q <= mode_t'(cfg_wdata[1:0]);
				REG_HUE_OFFSET: hoff_q <= cfg_wdata[HOFF_W-1:0];
				REG_SAT_GAIN:   gain_q <= cfg_wdata[GAIN_W-1:0];
				default:        ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: capture the beat
	logic              vld_s1;
	mode_t             mode_s1;
	logic [CHAN_W-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode_q;
		a_s1    <= pix_in.chan_in_a;
		b_s1    <= pix_in.chan_in_b;
		c_s1    <= pix_in.chan_in_c;
	end

	// max / min, and hue numerator by which channel is largest (first wins ties)
	logic [CHAN_W-1:0] mx, mn, dlt;
	logic [1:0]        which;
	logic signed [19:0] ra, gb, bc, n0, nh, d20;
	logic [DW-1:0]     den_h;

	always_comb begin
		mx    = a_s1;
		which = 2'd0;
		if (b_s1 > mx) begin
			mx    = b_s1;
			which = 2'd1;
		end
		if (c_s1 > mx) begin
			mx    = c_s1;
			which = 2'd2;
		end
		mn = a_s1;
		if (b_s1 < mn) mn = b_s1;
		if (c_s1 < mn) mn = c_s1;
		dlt = mx - mn;
		ra  = signed'({4'b0, a_s1});
		gb  = signed'({4'b0, b_s1});
		bc  = signed'({4'b0, c_s1});
		d20 = signed'({4'b0, dlt});
		n0  = '0;
		nh  = '0;
		case (which)
			2'd0: begin
				n0 = gb - bc;
				nh = (n0 < 0) ? n0 + (d20 <<< 2) + (d20 <<< 1) : n0;
			end
			2'd1:    nh = bc - ra + (d20 <<< 1);
			default: nh = ra - gb + (d20 <<< 2);
		endcase
		den_h = DW'({3'b0, dlt} << 2) + DW'({3'b0, dlt} << 1);
	end

	logic [QB-1:0] s_quo, h_quo;

	hsa_div #(.DW(DW), .QB(QB)) u_div_s (
		.clk (clk),
		.num ({3'b0, dlt}),
		.den ({3'b0, mx}),
		.quo (s_quo)
	);

	hsa_div #(.DW(DW), .QB(QB)) u_div_h (
		.clk (clk),
		.num (nh[DW-1:0]),
		.den (den_h),
		.quo (h_quo)
	);

	// side line, aligned with the dividers
	logic  vld_d_s [QB];
	side_t side_d_s [QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QB; k++) vld_d_s[k] <= 1'b0;
		end else begin
			vld_d_s[0] <= vld_s1;
			for (int k = 1; k < QB; k++) vld_d_s[k] <= vld_d_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		side_d_s[0] <= '{mode: mode_s1, a: a_s1, b: b_s1, c: c_s1, mx: mx,
			flat: (dlt == '0)};
		for (int k = 1; k < QB; k++) side_d_s[k] <= side_d_s[k-1];
	end

	// stage 2: pick h, s, v; hue shift; saturation gain product
	side_t         sd;
	logic [F-1:0]  h0;
	logic [QB-1:0] s0;
	logic [OW-1:0] hsum;

	assign sd   = side_d_s[QB-1];
	assign h0   = sd.flat ? '0 : h_quo[F-1:0];
	assign s0   = sd.flat ? '0 : s_quo;
	assign hsum = OW'(h0) + OW'(signed'(hoff_q));

	logic              vld_s2;
	mode_t             mode_s2;
	logic [XW-1:0]     h_s2, s_s2;
	logic [CHAN_W-1:0] v_s2;
	logic [PW-1:0]     prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_d_s[QB-1];
	end

	always_ff @(posedge clk) begin
		mode_s2 <= sd.mode;
		prod_s2 <= PW'(s0) * PW'(gain_q);
		case (sd.mode)
			MODE_TO_RGB: begin
				h_s2 <= XW'(sd.a);
				s_s2 <= XW'(sd.b);
				v_s2 <= sd.c;
			end
			MODE_HUE_SHIFT: begin
				h_s2 <= XW'(hsum[F-1:0]);
				s_s2 <= XW'(s0);
				v_s2 <= sd.mx;
			end
			default: begin
				h_s2 <= XW'(h0);
				s_s2 <= XW'(s0);
				v_s2 <= sd.mx;
			end
		endcase
	end

	// stage 3: clamp scaled saturation, hue sector terms
	logic [PW-F-1:0]        pscl;
	logic [XW-1:0]          s3;
	logic signed [CW-1:0]   hh;

	assign pscl = prod_s2[PW-1:F];
	assign s3   = (mode_s2 == MODE_SAT_SCALE) ?
		((pscl > (PW-F)'(ONE)) ? XW'(ONE) : XW'(pscl)) : s_s2;
	assign hh   = (signed'(CW'(h_s2)) <<< 2) + (signed'(CW'(h_s2)) <<< 1);

	logic              vld_s3;
	mode_t             mode_s3;
	logic [XW-1:0]     h_s3, s_s3;
	logic [CHAN_W-1:0] v_s3;
	logic [F:0]        cr_s3, cg_s3, cb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		h_s3    <= h_s2;
		s_s3    <= s3;
		v_s3    <= v_s2;
		cr_s3   <= clip_c(absv(hh - THREE_C) - ONE_C);
		cg_s3   <= clip_c(TWO_C - absv(hh - TWO_C));
		cb_s3   <= clip_c(TWO_C - absv(hh - FOUR_C));
	end

	// stage 4: t = (1 - c) * s
	localparam int TPW = F + 1 + XW;

	logic [TPW-1:0] tr_p, tg_p, tb_p;

	assign tr_p = TPW'(ONE - cr_s3) * TPW'(s_s3);
	assign tg_p = TPW'(ONE - cg_s3) * TPW'(s_s3);
	assign tb_p = TPW'(ONE - cb_s3) * TPW'(s_s3);

	logic              vld_s4;
	mode_t             mode_s4;
	logic [XW-1:0]     h_s4, s_s4;
	logic [CHAN_W-1:0] v_s4;
	logic [XW:0]       tr_s4, tg_s4, tb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		mode_s4 <= mode_s3;
		h_s4    <= h_s3;
		s_s4    <= s_s3;
		v_s4    <= v_s3;
		tr_s4   <= tr_p[TPW-1:F];
		tg_s4   <= tg_p[TPW-1:F];
		tb_s4   <= tb_p[TPW-1:F];
	end

	// stage 5: u = 1 - t, product u * v; u at or below zero gives zero
	localparam int UPW = F + 1 + CHAN_W;

	logic zr, zg, zb;
	logic [UPW-1:0] ur_p, ug_p, ub_p;

	assign zr   = tr_s4 >= (XW+1)'(ONE);
	assign zg   = tg_s4 >= (XW+1)'(ONE);
	assign zb   = tb_s4 >= (XW+1)'(ONE);
	assign ur_p = UPW'(ONE - tr_s4[F:0]) * UPW'(v_s4);
	assign ug_p = UPW'(ONE - tg_s4[F:0]) * UPW'(v_s4);
	assign ub_p = UPW'(ONE - tb_s4[F:0]) * UPW'(v_s4);

	logic              vld_s5;
	mode_t             mode_s5;
	logic [XW-1:0]     h_s5, s_s5;
	logic [CHAN_W-1:0] v_s5;
	logic [UPW-1:0]    pr_s5, pg_s5, pb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		mode_s5 <= mode_s4;
		h_s5    <= h_s4;
		s_s5    <= s_s4;
		v_s5    <= v_s4;
		pr_s5   <= zr ? '0 : ur_p;
		pg_s5   <= zg ? '0 : ug_p;
		pb_s5   <= zb ? '0 : ub_p;
	end

	// stage 6: saturate and drive the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (mode_s5 == MODE_TO_HSV) begin
			pix_out.chan_out_a <= sat16(32'(h_s5));
			pix_out.chan_out_b <= sat16(32'(s_s5));
			pix_out.chan_out_c <= sat16(32'(v_s5));
		end else begin
			pix_out.chan_out_a <= sat16(32'(pr_s5[UPW-1:F]));
			pix_out.chan_out_b <= sat16(32'(pg_s5[UPW-1:F]));
			pix_out.chan_out_c <= sat16(32'(pb_s5[UPW-1:F]));
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for pixel_hue_saturation_adjust_top: directed and random pixels in
// every mode, checked against an in-bench fixed-point HSV model. Depends on hsa_pkg and the DUT.
`timescale 1ns / 1ps

module tb_top;
	import hsa_pkg::*;

	localparam int FB      = 16;
	localparam longint ONE = 64'sd1 << FB;
	localparam int LAT     = FB + 7;
	localparam int WDOG    = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	pix_in_t pix_in = '0;
	logic done;
	pix_out_t pix_out;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = REG_MODE;
	logic [CFG_W-1:0] cfg_wdata = '0;

	mode_t cur_mode;
	logic [HOFF_W-1:0] cur_hoff;
	logic [GAIN_W-1:0] cur_gain;

	pix_out_t pending_pix[$];
	int n_errors = 0;
	int idle_cycles = 0;

	pixel_hue_saturation_adjust_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pix_in(pix_in),
		.done(done), .pix_out(pix_out), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] clamp_chan(longint x);
		if (x < 0)
			return 16'd0;
		if (x > ONE - 1)
			return 16'(ONE - 1);
		return 16'(x);
	endfunction

	function automatic longint abs_l(longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic logic [15:0] rgb_plane(longint c, longint s, longint v);
		longint t, u;
		if (c < 0) c = 0;
		if (c > ONE) c = ONE;
		t = ((ONE - c) * s) >>> FB;
		u = ONE - t;
		if (u <= 0)
			return 16'd0;
		return clamp_chan((u * v) >>> FB);
	endfunction

	function automatic pix_out_t hsv_to_rgb(longint h, longint s, longint v);
		pix_out_t o;
		longint hh;
		hh = 6 * h;
		o.chan_out_a = rgb_plane(abs_l(hh - 3 * ONE) - ONE, s, v);
		o.chan_out_b = rgb_plane(2 * ONE - abs_l(hh - 2 * ONE), s, v);
		o.chan_out_c = rgb_plane(2 * ONE - abs_l(hh - 4 * ONE), s, v);
		return o;
	endfunction

	function automatic pix_out_t adjust_pixel(pix_in_t p);
		longint r, g, b, mx, mn, d, n, h, s, v, off, prod;
		int which;
		pix_out_t o;
		r = p.chan_in_a; g = p.chan_in_b; b = p.chan_in_c;
		if (cur_mode == MODE_TO_RGB)
			return hsv_to_rgb(r, g, b);
		mx = r; mn = r; which = 0;
		if (g > mx) begin mx = g; which = 1; end
		if (b > mx) begin mx = b; which = 2; end
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		v = mx;
		if (d <= 0) begin
			h = 0; s = 0;
		end else begin
			s = (d << FB) / mx;
			if (which == 0) begin
				n = g - b;
				if (n < 0) n += 6 * d;
			end else if (which == 1) begin
				n = b - r + 2 * d;
			end else begin
				n = r - g + 4 * d;
			end
			h = (n << FB) / (6 * d);
		end
		if (cur_mode == MODE_TO_HSV) begin
			o.chan_out_a = clamp_chan(h);
			o.chan_out_b = clamp_chan(s);
			o.chan_out_c = clamp_chan(v);
			return o;
		end
		if (cur_mode == MODE_HUE_SHIFT) begin
			off = longint'($signed(cur_hoff));
			h = (h + off) & (ONE - 1);
		end else begin
			prod = (s * longint'(cur_gain)) >>> FB;
			s = (prod > ONE) ? ONE : prod;
		end
		return hsv_to_rgb(h, s, v);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		n_errors++;
	endtask

	// Check every result beat against the oldest prediction.
	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n && done) begin
			if (pending_pix.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				want = pending_pix.pop_front();
				if (pix_out.chan_out_a !== want.chan_out_a)
					report_mismatch("chan_out_a", pix_out.chan_out_a, want.chan_out_a);
				if (pix_out.chan_out_b !== want.chan_out_b)
					report_mismatch("chan_out_b", pix_out.chan_out_b, want.chan_out_b);
				if (pix_out.chan_out_c !== want.chan_out_c)
					report_mismatch("chan_out_c", pix_out.chan_out_c, want.chan_out_c);
			end
		end
	end

	always @(posedge clk) begin
		if ((arst_n && start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_pixel(pix_in_t p, bit may_idle);
		int gap;
		gap = may_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		pix_in <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_pix.push_back(adjust_pixel(p));
		@(negedge clk);
	endtask

	task automatic finish_burst();
		start <= 1'b0;
		while (pending_pix.size() != 0)
			@(negedge clk);
		repeat (LAT + 4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_MODE:       cur_mode = mode_t'(val[1:0]);
			REG_HUE_OFFSET: cur_hoff = val[HOFF_W-1:0];
			REG_SAT_GAIN:   cur_gain = val[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	function automatic pix_in_t mk(int a, int b, int c);
		pix_in_t p;
		p.chan_in_a = 16'(a); p.chan_in_b = 16'(b); p.chan_in_c = 16'(c);
		return p;
	endfunction

	function automatic pix_in_t rand_pixel();
		pix_in_t p;
		int k;
		p = pix_in_t'(48'({$urandom, $urandom}));
		k = $urandom_range(0, 9);
		// ties and flat pixels, plus full-scale corners
		if (k == 0) p.chan_in_b = p.chan_in_a;
		else if (k == 1) p.chan_in_c = p.chan_in_a;
		else if (k == 2) p.chan_in_c = p.chan_in_b;
		else if (k == 3) begin p.chan_in_b = p.chan_in_a; p.chan_in_c = p.chan_in_a; end
		else if (k == 4) p.chan_in_a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return p;
	endfunction

	// Extremes, ties for the maximum, flat pixels, each mode in turn.
	task automatic test_directed();
		write_reg(REG_HUE_OFFSET, 24'h01_0000 & 24'h3FFFF);
		write_reg(REG_SAT_GAIN, 24'd0);
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_MODE, CFG_W'(m));
			send_pixel(mk(0, 0, 0), 0);
			send_pixel(mk(65535, 65535, 65535), 0);
			send_pixel(mk(65535, 0, 0), 0);
			send_pixel(mk(0, 65535, 0), 0);
			send_pixel(mk(0, 0, 65535), 0);
			send_pixel(mk(1000, 1000, 20), 0);
			send_pixel(mk(500, 20, 500), 0);
			send_pixel(mk(7, 9000, 9000), 0);
			send_pixel(mk(100, 300, 200), 0);
			send_pixel(mk(65535, 1, 65534), 0);
			finish_burst();
		end
	endtask

	task automatic test_random_modes(int count);
		logic [CFG_W-1:0] hoffs[5];
		logic [CFG_W-1:0] gains[5];
		hoffs = '{24'h00000, 24'h10000, 24'h30000, 24'h1FFFF, 24'h20000};
		gains = '{24'h000000, 24'h010000, 24'hFFFFFF, 24'h008000, 24'h020000};
		for (int ph = 0; ph < 20; ph++) begin
			write_reg(REG_MODE, CFG_W'(ph % 4));
			if (ph < 5) begin
				write_reg(REG_HUE_OFFSET, hoffs[ph]);
				write_reg(REG_SAT_GAIN, gains[ph]);
			end else begin
				write_reg(REG_HUE_OFFSET, CFG_W'($urandom) & 24'h3FFFF);
				write_reg(REG_SAT_GAIN, CFG_W'($urandom));
			end
			for (int i = 0; i < count / 20; i++)
				send_pixel(rand_pixel(), (ph % 5) != 4);
			finish_burst();
		end
	endtask

	initial begin
		cur_mode = MODE_TO_HSV;
		cur_hoff = '0;
		cur_gain = GAIN_RESET;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_modes(1720);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
